>>> src/hsl_to_rgb_converter_defines.svh
// assertion macros for the hsl to rgb converter checker
// no dependencies; taken in by the checker file
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// condition now implies consequence in the next cycle
`define HSL2RGB_ASSERT_NEXT(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsl2rgb: next-cycle check failed");

// condition implies consequence in the same cycle
`define HSL2RGB_ASSERT_NOW(name, ck, rst_n, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsl2rgb: same-cycle check failed");

`endif

>>> src/hsl2rgb_pkg.sv
// types and constants for the hsl to rgb converter
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package hsl2rgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FIELD_W = 16;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [FRAC_BITS-1:0] fx_t;
	typedef logic [FRAC_BITS:0] fxw_t;
	typedef logic [FRAC_BITS+1:0] qsum_t;
	typedef logic [FRAC_BITS+2:0] six_t;
	typedef logic [FRAC_BITS+2:0] sum_t;
	typedef logic [2*FRAC_BITS-1:0] lsp_t;
	typedef logic [2*FRAC_BITS+1:0] prod_t;

	localparam fxw_t FX_ONE = fxw_t'(1) << FRAC_BITS;
	localparam fx_t FX_MAX = {FRAC_BITS{1'b1}};
	localparam fx_t FX_THIRD = fx_t'(((2 ** FRAC_BITS) + 1) / 3);
	localparam six_t SIX_ONE = six_t'(FX_ONE);
	localparam six_t SIX_FOUR = six_t'(FX_ONE) << 2;
	localparam six_t SIX_SIX = six_t'(6);

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	typedef struct packed {
		field_t hue;
		field_t saturation;
		field_t lightness;
	} hsl_t;

	typedef struct packed {
		field_t red;
		field_t green;
		field_t blue;
	} rgb_t;

endpackage

>>> src/hsl_to_rgb_converter.sv
// Converts one HSL pixel per clock into RGB. Every accepted beat passes
// through a six-stage pipeline (l*s product, q and hue offsets,
// p and ramp segment, ramp span, ramp product, add and saturate); the last
// stage is the output register. A new pixel is taken every cycle while the
// output side keeps up; a held result stops only the stages behind it and
// empty stages keep filling, so pixel_stall rises only with all six stages full.
// depends on hsl2rgb_pkg
`timescale 1ns / 1ps

module hsl_to_rgb_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  hsl2rgb_pkg::hsl_t  pixel,
	output logic               color_valid,
	input  logic               color_stall,
	output hsl2rgb_pkg::rgb_t  color
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	// stage 1
	hsl2rgb_pkg::fx_t  h_s1, s_s1, l_s1;
	hsl2rgb_pkg::lsp_t ls_s1;
	logic              zero_s1;
	// stage 2
	hsl2rgb_pkg::fx_t  l_s2;
	hsl2rgb_pkg::fxw_t q_s2;
	hsl2rgb_pkg::fx_t  t_s2 [3];
	logic              zero_s2;
	// stage 3
	hsl2rgb_pkg::fx_t  l_s3;
	hsl2rgb_pkg::fxw_t p_s3, q_s3;
	hsl2rgb_pkg::fxw_t m_s3 [3];
	hsl2rgb_pkg::seg_t seg_s3 [3];
	logic              zero_s3;
	// stage 4
	hsl2rgb_pkg::fx_t  l_s4;
	hsl2rgb_pkg::fxw_t p_s4, q_s4, d_s4;
	hsl2rgb_pkg::fxw_t m_s4 [3];
	hsl2rgb_pkg::seg_t seg_s4 [3];
	logic              zero_s4;
	// stage 5
	hsl2rgb_pkg::fx_t   l_s5;
	hsl2rgb_pkg::fxw_t  p_s5, q_s5;
	hsl2rgb_pkg::prod_t prod_s5 [3];
	hsl2rgb_pkg::seg_t  seg_s5 [3];
	logic               zero_s5;
	// stage 6
	hsl2rgb_pkg::rgb_t  color_s6;

	// back-pressure
	assign adv_s6 = !vld_s6 || !color_stall;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign pixel_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= pixel_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: l*s
	hsl2rgb_pkg::fx_t in_h, in_s, in_l;
	assign in_h = hsl2rgb_pkg::fx_t'(pixel.hue);
	assign in_s = hsl2rgb_pkg::fx_t'(pixel.saturation);
	assign in_l = hsl2rgb_pkg::fx_t'(pixel.lightness);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			h_s1    <= in_h;
			s_s1    <= in_s;
			l_s1    <= in_l;
			zero_s1 <= (in_s == '0);
			ls_s1   <= hsl2rgb_pkg::lsp_t'(in_l) * hsl2rgb_pkg::lsp_t'(in_s);
		end
	end

	// stage 2: q and hue offsets
	hsl2rgb_pkg::fx_t   ls_trunc;
	hsl2rgb_pkg::qsum_t q_sum;
	always_comb begin
		ls_trunc = ls_s1[2*hsl2rgb_pkg::FRAC_BITS-1:hsl2rgb_pkg::FRAC_BITS];
		if (!l_s1[hsl2rgb_pkg::FRAC_BITS-1]) begin
			q_sum = hsl2rgb_pkg::qsum_t'(l_s1) + hsl2rgb_pkg::qsum_t'(ls_trunc);
		end else begin
			q_sum = hsl2rgb_pkg::qsum_t'(l_s1) + hsl2rgb_pkg::qsum_t'(s_s1)
				- hsl2rgb_pkg::qsum_t'(ls_trunc);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			l_s2    <= l_s1;
			zero_s2 <= zero_s1;
			q_s2    <= hsl2rgb_pkg::fxw_t'(q_sum);
			t_s2[0] <= h_s1 + hsl2rgb_pkg::FX_THIRD;
			t_s2[1] <= h_s1;
			t_s2[2] <= h_s1 - hsl2rgb_pkg::FX_THIRD;
		end
	end

	// stage 3: p, ramp segment and slope factor
	hsl2rgb_pkg::fxw_t two_l, p_raw, p_cl;
	hsl2rgb_pkg::six_t six_t_c [3];
	hsl2rgb_pkg::fxw_t m_c [3];
	hsl2rgb_pkg::seg_t seg_c [3];
	always_comb begin
		two_l = {l_s2, 1'b0};
		p_raw = (two_l >= q_s2) ? two_l - q_s2 : '0;
		p_cl  = (p_raw > q_s2) ? q_s2 : p_raw;
		for (int c = 0; c < 3; c++) begin
			six_t_c[c] = hsl2rgb_pkg::six_t'(t_s2[c]) * hsl2rgb_pkg::SIX_SIX;
			if (six_t_c[c] < hsl2rgb_pkg::SIX_ONE) begin
				seg_c[c] = hsl2rgb_pkg::SEG_RISE;
			end else if (!t_s2[c][hsl2rgb_pkg::FRAC_BITS-1]) begin
				seg_c[c] = hsl2rgb_pkg::SEG_HIGH;
			end else if (six_t_c[c] < hsl2rgb_pkg::SIX_FOUR) begin
				seg_c[c] = hsl2rgb_pkg::SEG_FALL;
			end else begin
				seg_c[c] = hsl2rgb_pkg::SEG_LOW;
			end
			if (seg_c[c] == hsl2rgb_pkg::SEG_RISE) begin
				m_c[c] = hsl2rgb_pkg::fxw_t'(six_t_c[c]);
			end else begin
				m_c[c] = hsl2rgb_pkg::fxw_t'(hsl2rgb_pkg::SIX_FOUR - six_t_c[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			l_s3    <= l_s2;
			zero_s3 <= zero_s2;
			q_s3    <= q_s2;
			p_s3    <= p_cl;
			for (int c = 0; c < 3; c++) begin
				m_s3[c]   <= m_c[c];
				seg_s3[c] <= seg_c[c];
			end
		end
	end

	// stage 4: ramp span
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			l_s4    <= l_s3;
			zero_s4 <= zero_s3;
			q_s4    <= q_s3;
			p_s4    <= p_s3;
			d_s4    <= q_s3 - p_s3;
			for (int c = 0; c < 3; c++) begin
				m_s4[c]   <= m_s3[c];
				seg_s4[c] <= seg_s3[c];
			end
		end
	end

	// stage 5: span times slope
	always_ff @(posedge clk) begin
		if (adv_s5) begin
			l_s5    <= l_s4;
			zero_s5 <= zero_s4;
			q_s5    <= q_s4;
			p_s5    <= p_s4;
			for (int c = 0; c < 3; c++) begin
				prod_s5[c] <= hsl2rgb_pkg::prod_t'(d_s4) * hsl2rgb_pkg::prod_t'(m_s4[c]);
				seg_s5[c]  <= seg_s4[c];
			end
		end
	end

	// stage 6: offset, saturate, select
	hsl2rgb_pkg::sum_t sum_c [3];
	hsl2rgb_pkg::fx_t  chan_c [3];
	hsl2rgb_pkg::rgb_t color_c;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			unique case (seg_s5[c])
				hsl2rgb_pkg::SEG_RISE, hsl2rgb_pkg::SEG_FALL: begin
					sum_c[c] = hsl2rgb_pkg::sum_t'(p_s5) + hsl2rgb_pkg::sum_t'(
						prod_s5[c][2*hsl2rgb_pkg::FRAC_BITS+1:hsl2rgb_pkg::FRAC_BITS]);
				end
				hsl2rgb_pkg::SEG_HIGH: begin
					sum_c[c] = hsl2rgb_pkg::sum_t'(q_s5);
				end
				default: begin
					sum_c[c] = hsl2rgb_pkg::sum_t'(p_s5);
				end
			endcase
			if (zero_s5) begin
				chan_c[c] = l_s5;
			end else if (sum_c[c] >= hsl2rgb_pkg::sum_t'(hsl2rgb_pkg::FX_ONE)) begin
				chan_c[c] = hsl2rgb_pkg::FX_MAX;
			end else begin
				chan_c[c] = hsl2rgb_pkg::fx_t'(sum_c[c]);
			end
		end
		color_c.red   = hsl2rgb_pkg::field_t'(chan_c[0]);
		color_c.green = hsl2rgb_pkg::field_t'(chan_c[1]);
		color_c.blue  = hsl2rgb_pkg::field_t'(chan_c[2]);
	end

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			color_s6 <= color_c;
		end
	end

	assign color_valid = vld_s6;
	assign color       = color_s6;

endmodule

>>> src/hsl2rgb_chk.sv
// port-level checker for the hsl to rgb converter, bound to the top level
// depends on hsl2rgb_pkg and hsl_to_rgb_converter_defines.svh
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_defines.svh"

module hsl2rgb_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              pixel_valid,
	input logic              pixel_stall,
	input hsl2rgb_pkg::hsl_t pixel,
	input logic              color_valid,
	input logic              color_stall,
	input hsl2rgb_pkg::rgb_t color
);

	logic       idle;
	logic       held;
	logic [4:0] idle_hist_q;
	assign idle = !pixel_valid && !color_stall && (pixel.hue == pixel.hue);
	assign held = color_valid && color_stall;

	// five-bit shift register of past idle flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_hist_q <= '0;
		end else begin
			idle_hist_q <= {idle_hist_q[3:0], idle};
		end
	end

	// a held result beat stays put
	`HSL2RGB_ASSERT_NEXT(a_out_hold, clk, arst_n, held, color_valid && $stable(color))

	// input back-pressure only with a full pipe behind a held result
	`HSL2RGB_ASSERT_NOW(a_stall_full, clk, arst_n, pixel_stall, color_valid && color_stall)

	// free-running cycles without input, through the whole idle history and now, drain the pipe
	`HSL2RGB_ASSERT_NEXT(a_drain, clk, arst_n, idle && (&idle_hist_q), !color_valid)

endmodule

bind hsl_to_rgb_converter hsl2rgb_chk u_hsl2rgb_chk (.*);
